>>> rtl/density_matrix_gate_apply_macros.svh
// ----------------------------------------------------------------------------
// Density matrix gate apply: assertion macros
// Shared concurrent assertion forms used by the RTL of this block.
// ----------------------------------------------------------------------------
`ifndef DENSITY_MATRIX_GATE_APPLY_MACROS_SVH
`define DENSITY_MATRIX_GATE_APPLY_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define DMGA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define DMGA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/dmga_pkg.sv
// ----------------------------------------------------------------------------
// Density matrix gate apply: package
// Sizes, codes, sequencer states and the multiply unit control word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dmga_pkg;

   localparam int MAX_QUBITS  = 5;
   localparam int VALUE_WIDTH = 32;
   localparam int FRAC_BITS   = VALUE_WIDTH - 2;
   localparam int QUBIT_W     = 3;
   localparam int ADDR_W      = 2 * MAX_QUBITS;
   localparam int CELLS       = 1 << ADDR_W;
   localparam int CELL_W      = 2 * VALUE_WIDTH;
   localparam int PROD_W      = 2 * VALUE_WIDTH;
   localparam int RND_W       = VALUE_WIDTH + 4;
   localparam int ACC_W       = VALUE_WIDTH + 6;

   localparam logic [VALUE_WIDTH-1:0] ONE_VAL = VALUE_WIDTH'(1) << FRAC_BITS;
   localparam logic [PROD_W-1:0]      RND_VAL = PROD_W'(1) << (FRAC_BITS - 1);

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_KLOAD = 2'd2,
      OP_APPLY = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_READ    = 2'd0,
      KIND_APPLIED = 2'd1,
      KIND_REJECT  = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_ROW,
      ST_COL,
      ST_MUL,
      ST_ACC,
      ST_WRITE,
      ST_STORE,
      ST_NEXT
   } state_type;

   // control word for the shared multiply-round-accumulate unit
   typedef struct packed {
      logic mul_en;   // form product
      logic acc_en;   // round and accumulate product
      logic first;    // first term of a sum
      logic negp;     // negate product before rounding
      logic sub;      // subtract rounded product
   } mac_ctl_type;

endpackage

>>> rtl/density_matrix_gate_apply.sv
// Write entry and load kernel entry: no result. Read entry: the store registers
// the read data, then the result is registered and strobed. Rejected item:
// strobe the next cycle. Apply: the block walk visits every matrix entry; each
// 2x2 block uses 64 products on the one shared multiplier, fewer per side where
// the control bit is zero; busy until the strobe. Results cannot be held off.
// After reset a clearing pass writes all 1024 entries, busy high.
// ----------------------------------------------------------------------------
// Density matrix gate apply: top level
// Complex density matrix with in-place U rho U^H update on a target qubit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "density_matrix_gate_apply_macros.svh"

module density_matrix_gate_apply (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic [1:0]                              req_opcode,
   input  logic [dmga_pkg::MAX_QUBITS-1:0]         req_row,
   input  logic [dmga_pkg::MAX_QUBITS-1:0]         req_col,
   input  logic signed [dmga_pkg::VALUE_WIDTH-1:0] req_value_real,
   input  logic signed [dmga_pkg::VALUE_WIDTH-1:0] req_value_imag,
   input  logic [1:0]                              req_kernel_slot,
   input  logic [dmga_pkg::QUBIT_W-1:0]            req_target_qubit,
   input  logic [dmga_pkg::QUBIT_W-1:0]            req_control_qubit,
   input  logic                                    req_use_control,
   input  logic                                    csr_write_en,
   input  logic [2:0]                              csr_write_data,
   output logic                                    rsp_strobe,
   output logic [1:0]                              rsp_result_kind,
   output logic signed [dmga_pkg::VALUE_WIDTH-1:0] rsp_out_real,
   output logic signed [dmga_pkg::VALUE_WIDTH-1:0] rsp_out_imag
);
   import dmga_pkg::*;

   localparam int MQ = MAX_QUBITS;
   localparam int VW = VALUE_WIDTH;

   state_type              state_ff, state_in;
   logic [2:0]             qcnt_ff;
   logic [QUBIT_W-1:0]     n_act;
   logic [MQ:0]            dim_act;
   logic                   accept, rw_bad, apply_bad;
   logic [QUBIT_W-1:0]     tq_ff, tq_in, cq_ff, cq_in;
   logic                   ctl_ff, ctl_in;
   logic [MQ-1:0]          ts;
   logic [MQ:0]            r_ff, r_in, c_ff, c_in, r_nx, c_nx, r_sh, c_sh;
   logic [2:0]             cnt_ff, cnt_in;
   logic [ADDR_W-1:0]      clr_ff, clr_in;
   logic                   stg_ff, stg_in, part_ff, part_in;
   logic [1:0]             ent_ff, ent_in, term_ff, term_in;
   logic                   ld_blk, cp_row, cp_col, wr_res;
   logic [1:0]             ld_idx;

   logic signed [VW-1:0]   blk_re_ff [4];
   logic signed [VW-1:0]   blk_im_ff [4];
   logic signed [VW-1:0]   tt_re_ff  [4];
   logic signed [VW-1:0]   tt_im_ff  [4];
   logic signed [VW-1:0]   ker_re_ff [4];
   logic signed [VW-1:0]   ker_im_ff [4];

   logic                   mem_we;
   logic [ADDR_W-1:0]      mem_waddr, mem_raddr;
   logic [CELL_W-1:0]      mem_wdata, mem_rdata;

   mac_ctl_type            mac_ctl;
   logic signed [VW-1:0]   mac_x, mac_y, mac_sum;
   logic [1:0]             k_idx, b_idx;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_kind_ff, rsp_kind_in;
   logic signed [VW-1:0]   rsp_re_ff, rsp_re_in, rsp_im_ff, rsp_im_in;

   // address of one entry of the current 2x2 block
   function automatic logic [ADDR_W-1:0] cell_addr(input logic [MQ:0] r, input logic [MQ:0] c,
                                                   input logic [MQ-1:0] s, input logic [1:0] e);
      logic [MQ-1:0] rr, cc;
      rr = r[MQ-1:0] | (e[1] ? s : '0);
      cc = c[MQ-1:0] | (e[0] ? s : '0);
      return {rr, cc};
   endfunction

   // active size and item checks
   always_comb begin
      if (qcnt_ff == 3'd0) begin
         n_act = QUBIT_W'(1);
      end else if (qcnt_ff > 3'(MQ)) begin
         n_act = QUBIT_W'(MQ);
      end else begin
         n_act = qcnt_ff;
      end
   end

   assign dim_act   = (MQ+1)'(1) << n_act;
   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign rw_bad    = ({1'b0, req_row} >= dim_act) || ({1'b0, req_col} >= dim_act);
   assign apply_bad = (req_target_qubit >= n_act) ||
                      (req_use_control && ((req_control_qubit >= n_act) ||
                                           (req_control_qubit == req_target_qubit)));
   assign ts        = MQ'(1) << tq_ff;
   assign r_sh      = r_ff >> cq_ff;
   assign c_sh      = c_ff >> cq_ff;
   assign ld_idx    = cnt_ff[1:0] - 2'd1;

   // operand selection for the shared multiplier
   always_comb begin
      if (!stg_ff) begin
         k_idx = {ent_ff[1], term_ff[1]};
         b_idx = {term_ff[1], ent_ff[0]};
         mac_x = term_ff[0] ? ker_im_ff[k_idx] : ker_re_ff[k_idx];
         mac_y = (term_ff[0] ^ part_ff) ? blk_im_ff[b_idx] : blk_re_ff[b_idx];
      end else begin
         k_idx = {ent_ff[0], term_ff[1]};
         b_idx = {ent_ff[1], term_ff[1]};
         mac_x = term_ff[0] ? tt_im_ff[b_idx] : tt_re_ff[b_idx];
         mac_y = (term_ff[0] ^ part_ff) ? ker_im_ff[k_idx] : ker_re_ff[k_idx];
      end
   end

   // sequencer: next state and controls
   always_comb begin
      state_in     = state_ff;
      tq_in        = tq_ff;
      cq_in        = cq_ff;
      ctl_in       = ctl_ff;
      r_in         = r_ff;
      c_in         = c_ff;
      cnt_in       = cnt_ff;
      clr_in       = clr_ff;
      stg_in       = stg_ff;
      part_in      = part_ff;
      ent_in       = ent_ff;
      term_in      = term_ff;
      ld_blk       = 1'b0;
      cp_row       = 1'b0;
      cp_col       = 1'b0;
      wr_res       = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '0;
      mem_raddr    = '0;
      mac_ctl      = '0;
      rsp_valid_in = 1'b0;
      rsp_kind_in  = KIND_REJECT;
      rsp_re_in    = '0;
      rsp_im_in    = '0;
      r_nx         = r_ff;
      c_nx         = c_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = (clr_ff == '0) ? {ONE_VAL, {VW{1'b0}}} : '0;
            clr_in    = clr_ff + ADDR_W'(1);
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (op_type'(req_opcode))
                  OP_WRITE: begin
                     if (rw_bad) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = {req_row, req_col};
                        mem_wdata = {req_value_real, req_value_imag};
                     end
                  end
                  OP_READ: begin
                     if (rw_bad) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        mem_raddr = {req_row, req_col};
                        state_in  = ST_READ;
                     end
                  end
                  OP_KLOAD: begin
                  end
                  OP_APPLY: begin
                     if (apply_bad) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        tq_in    = req_target_qubit;
                        cq_in    = req_control_qubit;
                        ctl_in   = req_use_control;
                        r_in     = '0;
                        c_in     = '0;
                        cnt_in   = '0;
                        state_in = ST_LOAD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = KIND_READ;
            rsp_re_in    = mem_rdata[CELL_W-1:VW];
            rsp_im_in    = mem_rdata[VW-1:0];
            state_in     = ST_IDLE;
         end
         ST_LOAD: begin
            mem_raddr = cell_addr(r_ff, c_ff, ts, cnt_ff[1:0]);
            ld_blk    = (cnt_ff != 3'd0);
            if (cnt_ff == 3'd4) begin
               cnt_in   = '0;
               state_in = ST_ROW;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         ST_ROW: begin
            if (!ctl_ff || r_sh[0]) begin
               stg_in   = 1'b0;
               ent_in   = '0;
               part_in  = 1'b0;
               term_in  = '0;
               state_in = ST_MUL;
            end else begin
               cp_row   = 1'b1;
               state_in = ST_COL;
            end
         end
         ST_COL: begin
            if (!ctl_ff || c_sh[0]) begin
               stg_in   = 1'b1;
               ent_in   = '0;
               part_in  = 1'b0;
               term_in  = '0;
               state_in = ST_MUL;
            end else begin
               cp_col   = 1'b1;
               cnt_in   = '0;
               state_in = ST_STORE;
            end
         end
         ST_MUL: begin
            mac_ctl.mul_en = 1'b1;
            mac_ctl.negp   = stg_ff & (term_ff[0] ^ part_ff);
            mac_ctl.sub    = !part_ff & term_ff[0];
            state_in       = ST_ACC;
         end
         ST_ACC: begin
            mac_ctl.acc_en = 1'b1;
            mac_ctl.first  = (term_ff == 2'd0);
            if (term_ff == 2'd3) begin
               state_in = ST_WRITE;
            end else begin
               term_in  = term_ff + 2'd1;
               state_in = ST_MUL;
            end
         end
         ST_WRITE: begin
            wr_res  = 1'b1;
            term_in = '0;
            if (!part_ff) begin
               part_in  = 1'b1;
               state_in = ST_MUL;
            end else begin
               part_in = 1'b0;
               if (ent_ff == 2'd3) begin
                  if (!stg_ff) begin
                     state_in = ST_COL;
                  end else begin
                     cnt_in   = '0;
                     state_in = ST_STORE;
                  end
               end else begin
                  ent_in   = ent_ff + 2'd1;
                  state_in = ST_MUL;
               end
            end
         end
         ST_STORE: begin
            mem_we    = 1'b1;
            mem_waddr = cell_addr(r_ff, c_ff, ts, cnt_ff[1:0]);
            mem_wdata = {blk_re_ff[cnt_ff[1:0]], blk_im_ff[cnt_ff[1:0]]};
            if (cnt_ff == 3'd3) begin
               state_in = ST_NEXT;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         ST_NEXT: begin
            // step to the next (row, col) pair, skipping target-bit-set indices
            if ((c_ff + (MQ+1)'(1)) == dim_act) begin
               c_nx = '0;
               r_nx = r_ff + (MQ+1)'(1);
            end else begin
               c_nx = c_ff + (MQ+1)'(1);
               r_nx = r_ff;
            end
            if (r_nx == dim_act) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_APPLIED;
               state_in     = ST_IDLE;
            end else begin
               r_in = r_nx;
               c_in = c_nx;
               if (((r_nx[MQ-1:0] | c_nx[MQ-1:0]) & ts) == '0) begin
                  cnt_in   = '0;
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         qcnt_ff      <= 3'd5;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            qcnt_ff <= csr_write_data;
         end
      end
   end

   // sequencer counters and result payload
   always_ff @(posedge clock) begin
      tq_ff       <= tq_in;
      cq_ff       <= cq_in;
      ctl_ff      <= ctl_in;
      r_ff        <= r_in;
      c_ff        <= c_in;
      cnt_ff      <= cnt_in;
      stg_ff      <= stg_in;
      part_ff     <= part_in;
      ent_ff      <= ent_in;
      term_ff     <= term_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_re_ff   <= rsp_re_in;
      rsp_im_ff   <= rsp_im_in;
   end

   // kernel and block working registers
   always_ff @(posedge clock) begin
      if (accept && (req_opcode == OP_KLOAD)) begin
         ker_re_ff[req_kernel_slot] <= req_value_real;
         ker_im_ff[req_kernel_slot] <= req_value_imag;
      end
      if (ld_blk) begin
         blk_re_ff[ld_idx] <= mem_rdata[CELL_W-1:VW];
         blk_im_ff[ld_idx] <= mem_rdata[VW-1:0];
      end
      if (cp_row) begin
         for (int i = 0; i < 4; i++) begin
            tt_re_ff[i] <= blk_re_ff[i];
            tt_im_ff[i] <= blk_im_ff[i];
         end
      end
      if (cp_col) begin
         for (int i = 0; i < 4; i++) begin
            blk_re_ff[i] <= tt_re_ff[i];
            blk_im_ff[i] <= tt_im_ff[i];
         end
      end
      if (wr_res) begin
         if (!stg_ff) begin
            if (part_ff) tt_im_ff[ent_ff] <= mac_sum;
            else         tt_re_ff[ent_ff] <= mac_sum;
         end else begin
            if (part_ff) blk_im_ff[ent_ff] <= mac_sum;
            else         blk_re_ff[ent_ff] <= mac_sum;
         end
      end
   end

   dmga_store u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   dmga_mac u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .x     (mac_x),
      .y     (mac_y),
      .sum   (mac_sum)
   );

   assign rsp_strobe      = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_out_real    = rsp_re_ff;
   assign rsp_out_imag    = rsp_im_ff;

   // checks
   `DMGA_ASSERT_NEXT(a_apply_goes_busy, clock, reset, accept && (req_opcode == OP_APPLY) && !apply_bad, busy, "valid apply did not start the block walk")
   `DMGA_ASSERT_SAME(a_applied_after_walk, clock, reset, rsp_valid_ff && (rsp_kind_ff == KIND_APPLIED), $past(state_ff) == ST_NEXT, "apply result without finished walk")
   `DMGA_ASSERT_SAME(a_store_writes, clock, reset, (state_ff == ST_STORE) || (state_ff == ST_CLEAR), mem_we, "block store or clear without memory write")

endmodule

>>> rtl/dmga_store.sv
// ----------------------------------------------------------------------------
// Density matrix gate apply: matrix store
// Single-write, single-read memory of complex entries, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dmga_store (
   input  logic                        clock,
   input  logic                        we,
   input  logic [dmga_pkg::ADDR_W-1:0] waddr,
   input  logic [dmga_pkg::CELL_W-1:0] wdata,
   input  logic [dmga_pkg::ADDR_W-1:0] raddr,
   output logic [dmga_pkg::CELL_W-1:0] rdata
);
   import dmga_pkg::*;

   logic [CELL_W-1:0] mem [CELLS];
   logic [CELL_W-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/dmga_mac.sv
// ----------------------------------------------------------------------------
// Density matrix gate apply: multiply-round-accumulate unit
// One real product per use, rounded to the fraction width, summed, saturated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dmga_mac (
   input  logic                                   clock,
   input  dmga_pkg::mac_ctl_type                  ctl,
   input  logic signed [dmga_pkg::VALUE_WIDTH-1:0] x,
   input  logic signed [dmga_pkg::VALUE_WIDTH-1:0] y,
   output logic signed [dmga_pkg::VALUE_WIDTH-1:0] sum
);
   import dmga_pkg::*;

   logic signed [PROD_W-1:0] mult;
   logic signed [PROD_W-1:0] prod_in, prod_ff;
   logic                     sub_ff;
   logic signed [PROD_W-1:0] rsum;
   logic signed [RND_W-1:0]  rnd, term;
   logic signed [ACC_W-1:0]  acc_in, acc_ff;

   // product stage
   assign mult    = PROD_W'(x) * PROD_W'(y);
   assign prod_in = ctl.negp ? -mult : mult;

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= prod_in;
         sub_ff  <= ctl.sub;
      end
   end

   // round to nearest (half up), then accumulate
   assign rsum   = prod_ff + $signed(RND_VAL);
   assign rnd    = RND_W'(rsum >>> FRAC_BITS);
   assign term   = sub_ff ? -rnd : rnd;
   assign acc_in = (ctl.first ? ACC_W'(0) : acc_ff) + ACC_W'(term);

   always_ff @(posedge clock) begin
      if (ctl.acc_en) begin
         acc_ff <= acc_in;
      end
   end

   // saturate to the value range
   always_comb begin
      if (acc_ff[ACC_W-1:VALUE_WIDTH-1] == '0 || acc_ff[ACC_W-1:VALUE_WIDTH-1] == '1) begin
         sum = acc_ff[VALUE_WIDTH-1:0];
      end else if (acc_ff[ACC_W-1]) begin
         sum = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
      end else begin
         sum = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
      end
   end

endmodule
